// ===== design/gdd_pkg.sv =====
// Shared widths, constants, control structs and calendar tables for the day difference block.
`default_nettype none

package gdd_pkg;

   // Field widths
   localparam int DAY_W       = 5;
   localparam int MONTH_W     = 4;
   localparam int YEAR_W      = 14;
   localparam int DIFF_W      = 23;
   localparam int DAYNUM_W    = 23;
   localparam int MAX_YEAR_W  = 16;
   localparam int MAX_YEAR_DEF = 9999;

   // Reciprocal division of a year count by 100: (p * 5243) >> 19 is exact below 43690
   localparam int          RECIP_W       = 13;
   localparam int          PROD_W        = YEAR_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
   localparam int          DIV100_SHIFT  = 19;
   localparam int          Q_W           = 8;
   localparam int          REM_W         = 7;
   localparam int          CORR_W        = 13;
   localparam int          OFFSET_W      = 9;

   // Calendar constants
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [REM_W-1:0]   CENTURY_LAST = 7'd99;
   localparam int                 DAYS_PER_YEAR = 365;
   localparam int                 DAYS_PER_CENTURY_DIV = 100;

   // Stage enables for the date units
   typedef struct packed {
      logic s1;
      logic s2;
      logic s3;
   } date_ctl_type;

   // Stage enables for the difference unit
   typedef struct packed {
      logic s4;
      logic s5;
   } diff_ctl_type;

   // Length of a month; zero for a month code that means nothing
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

   // Days in the year before the first of a month (common year)
   function automatic logic [OFFSET_W-1:0] days_before(input logic [MONTH_W-1:0] m);
      logic [OFFSET_W-1:0] n;
      case (m)
         4'd1:    n = 9'd0;
         4'd2:    n = 9'd31;
         4'd3:    n = 9'd59;
         4'd4:    n = 9'd90;
         4'd5:    n = 9'd120;
         4'd6:    n = 9'd151;
         4'd7:    n = 9'd181;
         4'd8:    n = 9'd212;
         4'd9:    n = 9'd243;
         4'd10:   n = 9'd273;
         4'd11:   n = 9'd304;
         4'd12:   n = 9'd334;
         default: n = 9'd0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== design/gdd_date_unit.sv =====
// Three-stage conversion of one date into a day number with a validity check.
`default_nettype none

module gdd_date_unit #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
   input  wire logic                          clock,
   input  wire gdd_pkg::date_ctl_type         ctl,
   input  wire logic [gdd_pkg::DAY_W-1:0]     day,
   input  wire logic [gdd_pkg::MONTH_W-1:0]   month,
   input  wire logic [gdd_pkg::YEAR_W-1:0]    year,
   output logic      [gdd_pkg::DAYNUM_W-1:0]  day_num,
   output logic                               date_ok
);
   import gdd_pkg::*;

   // Stage 1 registers
   logic [DAY_W-1:0]    day1_ff;
   logic [MONTH_W-1:0]  month1_ff;
   logic [YEAR_W-1:0]   p1_ff, p1_in;
   logic [Q_W-1:0]      q1_ff, q1_in;
   logic                ok1_ff, ok1_in;
   logic [PROD_W-1:0]   prod;

   // Stage 2 registers
   logic [DAY_W-1:0]    day2_ff;
   logic [DAYNUM_W-1:0] base2_ff, base2_in;
   logic [CORR_W-1:0]   corr2_ff, corr2_in;
   logic [OFFSET_W-1:0] offset2_ff, offset2_in;
   logic                ok2_ff, ok2_in;
   logic [REM_W-1:0]    rem;
   logic                leap;
   logic [DAY_W-1:0]    len;

   // Stage 3 registers
   logic [DAYNUM_W-1:0] num3_ff, num3_in;
   logic                ok3_ff;

   // Stage 1: years before the date, centuries by reciprocal, year and month range
   always_comb begin
      p1_in  = year - YEAR_W'(1);
      prod   = PROD_W'(p1_in) * PROD_W'(RECIP_100);
      q1_in  = Q_W'(prod >> DIV100_SHIFT);
      ok1_in = (year != '0)
             && ({{(MAX_YEAR_W-YEAR_W){1'b0}}, year} <= MAX_YEAR_W'(MAX_YEAR))
             && (month >= MONTH_JAN) && (month <= MONTH_DEC);
   end

   always_ff @(posedge clock) begin
      if (ctl.s1) begin
         day1_ff   <= day;
         month1_ff <= month;
         p1_ff     <= p1_in;
         q1_ff     <= q1_in;
         ok1_ff    <= ok1_in;
      end
   end

   // Stage 2: leap rule, day check, whole-year days and month offset
   always_comb begin
      rem  = REM_W'(p1_ff - YEAR_W'(q1_ff) * YEAR_W'(DAYS_PER_CENTURY_DIV));
      // year is a leap year when p ends in ...3 mod 4, and not a century unless mod 400
      leap = (p1_ff[1:0] == 2'b11) && ((rem != CENTURY_LAST) || (q1_ff[1:0] == 2'b11));
      len  = month_days(month1_ff, leap);
      ok2_in     = ok1_ff && (day1_ff != '0) && (day1_ff <= len);
      base2_in   = DAYNUM_W'(p1_ff) * DAYNUM_W'(DAYS_PER_YEAR);
      corr2_in   = CORR_W'(p1_ff >> 2) + CORR_W'(q1_ff >> 2) - CORR_W'(q1_ff);
      offset2_in = days_before(month1_ff)
                 + OFFSET_W'((month1_ff > MONTH_FEB) && leap);
   end

   always_ff @(posedge clock) begin
      if (ctl.s2) begin
         day2_ff    <= day1_ff;
         base2_ff   <= base2_in;
         corr2_ff   <= corr2_in;
         offset2_ff <= offset2_in;
         ok2_ff     <= ok2_in;
      end
   end

   // Stage 3: sum the day number
   assign num3_in = base2_ff + DAYNUM_W'(corr2_ff) + DAYNUM_W'(offset2_ff)
                  + DAYNUM_W'(day2_ff);

   always_ff @(posedge clock) begin
      if (ctl.s3) begin
         num3_ff <= num3_in;
         ok3_ff  <= ok2_ff;
      end
   end

   assign day_num = num3_ff;
   assign date_ok = ok3_ff;

endmodule

`default_nettype wire

// ===== design/gdd_diff_unit.sv =====
// Two-stage subtraction of day numbers with end-day adjustment and invalid masking.
`default_nettype none

module gdd_diff_unit (
   input  wire logic                                clock,
   input  wire gdd_pkg::diff_ctl_type               ctl,
   input  wire logic [gdd_pkg::DAYNUM_W-1:0]        first_num,
   input  wire logic [gdd_pkg::DAYNUM_W-1:0]        second_num,
   input  wire logic                                first_ok,
   input  wire logic                                second_ok,
   input  wire logic                                include_end_day,
   output logic signed [gdd_pkg::DIFF_W-1:0]       day_difference,
   output logic                                     invalid_date
);
   import gdd_pkg::*;

   localparam int WIDE_W = DAYNUM_W + 1;

   logic signed [WIDE_W-1:0] diff4_ff, diff4_in;
   logic                     inc4_ff;
   logic                     bad4_ff;
   logic signed [WIDE_W-1:0] step;
   logic signed [WIDE_W-1:0] sum;
   logic signed [DIFF_W-1:0] out5_ff, out5_in;
   logic                     bad5_ff;

   // Stage 4: raw difference
   assign diff4_in = signed'({1'b0, second_num}) - signed'({1'b0, first_num});

   always_ff @(posedge clock) begin
      if (ctl.s4) begin
         diff4_ff <= diff4_in;
         inc4_ff  <= include_end_day;
         bad4_ff  <= !(first_ok && second_ok);
      end
   end

   // Stage 5: step one day away from zero, zero the result of an impossible date
   always_comb begin
      if (!inc4_ff) begin
         step = '0;
      end else if (diff4_ff[WIDE_W-1]) begin
         step = '1;
      end else begin
         step = WIDE_W'(1);
      end
      sum     = diff4_ff + step;
      out5_in = bad4_ff ? '0 : signed'(sum[DIFF_W-1:0]);
   end

   always_ff @(posedge clock) begin
      if (ctl.s5) begin
         out5_ff <= out5_in;
         bad5_ff <= bad4_ff;
      end
   end

   assign day_difference = out5_ff;
   assign invalid_date   = bad5_ff;

endmodule

`default_nettype wire

// ===== design/gregorian_day_difference.sv =====
// Top level: days between two Gregorian dates, five-stage pipeline.
`default_nettype none

// Gives the signed day count from the first date to the second, one request per
// cycle while the result side does not stall; a request passes through the five
// register stages in order. Each stage holds its own valid bit and moves as soon
// as the stage after it has room, so bubbles are squeezed out and requests keep
// coming in while a result waits, until every stage is full. Stages one to
// three turn each date into a day number (reciprocal divide by 100, leap rule,
// month table, final sum); stages four and five subtract and apply the end-day
// step. A date with an impossible day, month or year (0 or above MAX_YEAR)
// sets rsp_invalid_date and gives a difference of zero.
module gregorian_day_difference #(
   parameter int MAX_YEAR = gdd_pkg::MAX_YEAR_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [gdd_pkg::DAY_W-1:0]          req_first_day,
   input  wire logic [gdd_pkg::MONTH_W-1:0]        req_first_month,
   input  wire logic [gdd_pkg::YEAR_W-1:0]         req_first_year,
   input  wire logic [gdd_pkg::DAY_W-1:0]          req_second_day,
   input  wire logic [gdd_pkg::MONTH_W-1:0]        req_second_month,
   input  wire logic [gdd_pkg::YEAR_W-1:0]         req_second_year,
   input  wire logic                               req_include_end_day,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [gdd_pkg::DIFF_W-1:0]       rsp_day_difference,
   output logic                                    rsp_invalid_date
);
   import gdd_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;
   logic inc1_ff, inc2_ff, inc3_ff;
   date_ctl_type date_ctl;
   diff_ctl_type diff_ctl;
   logic [DAYNUM_W-1:0] first_num, second_num;
   logic first_ok, second_ok;

   // Each stage loads when it is empty or the stage after it moves
   assign rdy5 = !v5_ff || !rsp_stall;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign date_ctl = '{s1: rdy1, s2: rdy2, s3: rdy3};
   assign diff_ctl = '{s4: rdy4, s5: rdy5};

   assign req_stall = !rdy1;
   assign rsp_valid = v5_ff;

   // Advance valid bits with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // Carry the end-day flag alongside the date stages
   always_ff @(posedge clock) begin
      if (rdy1) inc1_ff <= req_include_end_day;
      if (rdy2) inc2_ff <= inc1_ff;
      if (rdy3) inc3_ff <= inc2_ff;
   end

   gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_first (
      .clock   (clock),
      .ctl     (date_ctl),
      .day     (req_first_day),
      .month   (req_first_month),
      .year    (req_first_year),
      .day_num (first_num),
      .date_ok (first_ok)
   );

   gdd_date_unit #(.MAX_YEAR(MAX_YEAR)) u_second (
      .clock   (clock),
      .ctl     (date_ctl),
      .day     (req_second_day),
      .month   (req_second_month),
      .year    (req_second_year),
      .day_num (second_num),
      .date_ok (second_ok)
   );

   gdd_diff_unit u_diff (
      .clock           (clock),
      .ctl             (diff_ctl),
      .first_num       (first_num),
      .second_num      (second_num),
      .first_ok        (first_ok),
      .second_ok       (second_ok),
      .include_end_day (inc3_ff),
      .day_difference  (rsp_day_difference),
      .invalid_date    (rsp_invalid_date)
   );

   // An impossible date always comes out as a zero difference
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_invalid_date) |-> (rsp_day_difference == '0))
      else $error("invalid date with nonzero difference");

   // Input is held back only when every stage is full and the output is stalled
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid && !v1_ff && !v4_ff))
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
